// ===== rtl/core/opd_pkg.sv =====
package opd_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CNT_OUT_W = 7;

  typedef struct packed {
    logic valid;
    logic last;
    logic dup;
    logic stored;
  } opd_flags_t;

endpackage

// ===== rtl/core/opd_in_if.sv =====
interface opd_in_if;
  import opd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_item;

  modport source (output valid, value, last_item, input ready);
  modport sink   (input valid, value, last_item, output ready);
endinterface

// ===== rtl/core/opd_out_if.sv =====
interface opd_out_if;
  import opd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic                      kept;
  logic [CNT_OUT_W-1:0]      distinct_count;
  logic                      overflow;
  logic                      end_of_set;

  modport source (output valid, value_out, kept, distinct_count, overflow, end_of_set,
                  input ready);
  modport sink   (input valid, value_out, kept, distinct_count, overflow, end_of_set,
                  output ready);
endinterface

// ===== rtl/core/opd_cell.sv =====
module opd_cell #(
  parameter int unsigned CntW = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  opd_pkg::opd_flags_t                flags_i,
  input  logic signed [opd_pkg::VALUE_W-1:0] value_i,
  input  logic [CntW-1:0]                    cnt_i,
  output opd_pkg::opd_flags_t                flags_o,
  output logic signed [opd_pkg::VALUE_W-1:0] value_o,
  output logic [CntW-1:0]                    cnt_o
);
  import opd_pkg::*;

  logic                      full_q, full_d;
  logic signed [VALUE_W-1:0] entry_q;
  opd_flags_t                flags_q, flags_d;
  logic signed [VALUE_W-1:0] value_q;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      hit;
  logic                      store;

  assign hit   = flags_i.valid && full_q && (entry_q == value_i);
  assign store = flags_i.valid && !full_q && !flags_i.dup && !flags_i.stored;

  always_comb begin
    flags_d.valid  = flags_i.valid;
    flags_d.last   = flags_i.last;
    flags_d.dup    = flags_i.dup | hit;
    flags_d.stored = flags_i.stored | store;
    cnt_d          = cnt_i + CntW'(full_q) + CntW'(store);
    if (flags_i.valid && flags_i.last) begin
      full_d = 1'b0;
    end else begin
      full_d = full_q | store;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      full_q  <= 1'b0;
    end else if (en_i) begin
      flags_q <= flags_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_i;
      cnt_q   <= cnt_d;
      if (store) begin
        entry_q <= value_i;
      end
    end
  end

  assign flags_o = flags_q;
  assign value_o = value_q;
  assign cnt_o   = cnt_q;

endmodule

// ===== rtl/core/order_preserving_dedup.sv =====
// Order-preserving duplicate filter. Every input transaction yields exactly one
// output transaction, in order: the value echoed, kept=1 when the value is not in
// the table of the current set, the running distinct count and an overflow flag
// when a new value finds the table full. The table is a chain of TABLE_DEPTH
// cells; each transaction moves one cell per cycle and the chain accepts one
// transaction per cycle. A stalled output holds the whole chain. The set ends
// with last_item, after which the table clears without a dead cycle.
module order_preserving_dedup #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  opd_in_if.sink     in_i,
  opd_out_if.source  out_o
);
  import opd_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  opd_flags_t                flags [TABLE_DEPTH+1];
  logic signed [VALUE_W-1:0] value [TABLE_DEPTH+1];
  logic [CntW-1:0]           cnt   [TABLE_DEPTH+1];
  logic                      advance;
  logic [CntW+CNT_OUT_W-1:0] cnt_ext;

  assign advance  = !flags[TABLE_DEPTH].valid || out_o.ready;
  assign in_i.ready = advance;

  always_comb begin
    flags[0].valid  = in_i.valid;
    flags[0].last   = in_i.last_item;
    flags[0].dup    = 1'b0;
    flags[0].stored = 1'b0;
  end
  assign value[0] = in_i.value;
  assign cnt[0]   = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    opd_cell #(
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .flags_i (flags[g]),
      .value_i (value[g]),
      .cnt_i   (cnt[g]),
      .flags_o (flags[g+1]),
      .value_o (value[g+1]),
      .cnt_o   (cnt[g+1])
    );
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt[TABLE_DEPTH]};

  assign out_o.valid          = flags[TABLE_DEPTH].valid;
  assign out_o.value_out      = value[TABLE_DEPTH];
  assign out_o.kept           = !flags[TABLE_DEPTH].dup;
  assign out_o.overflow       = !flags[TABLE_DEPTH].dup && !flags[TABLE_DEPTH].stored;
  assign out_o.end_of_set     = flags[TABLE_DEPTH].last;
  assign out_o.distinct_count = cnt_ext[CNT_OUT_W-1:0];

endmodule

// ===== rtl/core/opd_checker.sv =====
module opd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [opd_pkg::VALUE_W-1:0] value_out_i,
  input logic                               kept_i,
  input logic [opd_pkg::CNT_OUT_W-1:0]      distinct_count_i,
  input logic                               overflow_i,
  input logic                               end_of_set_i
);
  import opd_pkg::*;

  logic out_hs;
  logic grew;

  assign out_hs = out_valid_i && out_ready_i;
  assign grew   = kept_i && !overflow_i;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_out_i))
    else $error("stalled output transaction changed");

  a_ovf_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> kept_i)
    else $error("overflow on a duplicate");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && $past(out_hs) && !$past(end_of_set_i) |->
      distinct_count_i == $past(distinct_count_i) + CNT_OUT_W'(grew))
    else $error("distinct count did not track kept values");

  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && $past(out_hs) && $past(end_of_set_i) |->
      distinct_count_i == CNT_OUT_W'(grew))
    else $error("distinct count did not restart after end of set");

endmodule

bind order_preserving_dedup opd_checker u_opd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .value_out_i      (out_o.value_out),
  .kept_i           (out_o.kept),
  .distinct_count_i (out_o.distinct_count),
  .overflow_i       (out_o.overflow),
  .end_of_set_i     (out_o.end_of_set)
);

// ===== tb/tb_order_preserving_dedup.sv =====
`timescale 1ns / 100ps

module tb_order_preserving_dedup;
  import opd_pkg::*;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned N_DIR    = 17;
  localparam int unsigned N_RANDOM = 1750;

  localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] V_NEG = -32'sd1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      kept;
    logic [CNT_OUT_W-1:0]      distinct_count;
    logic                      overflow;
    logic                      end_of_set;
  } dedup_result_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    bit                        typed;
    dedup_result_t             exp;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  opd_in_if  in_if ();
  opd_out_if out_if ();

  order_preserving_dedup #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // directed sets: single-item sets, extremes, duplicates, duplicate on the last item
  stim_row_t dir_rows [N_DIR] = '{
    '{32'sd0, 1'b1, 1'b1, '{32'sd0, 1'b1, 7'd1, 1'b0, 1'b1}},
    '{V_MIN,  1'b0, 1'b1, '{V_MIN,  1'b1, 7'd1, 1'b0, 1'b0}},
    '{V_MAX,  1'b0, 1'b1, '{V_MAX,  1'b1, 7'd2, 1'b0, 1'b0}},
    '{V_NEG,  1'b0, 1'b1, '{V_NEG,  1'b1, 7'd3, 1'b0, 1'b0}},
    '{V_MIN,  1'b0, 1'b1, '{V_MIN,  1'b0, 7'd3, 1'b0, 1'b0}},
    '{32'sd0, 1'b0, 1'b1, '{32'sd0, 1'b1, 7'd4, 1'b0, 1'b0}},
    '{32'sd1, 1'b0, 1'b0, '0},
    '{V_MAX,  1'b0, 1'b1, '{V_MAX,  1'b0, 7'd5, 1'b0, 1'b0}},
    '{32'sh5555_5555, 1'b0, 1'b0, '0},
    '{32'shAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'sh5555_5555, 1'b1, 1'b0, '0},
    '{V_MIN,  1'b1, 1'b1, '{V_MIN,  1'b1, 7'd1, 1'b0, 1'b1}},
    '{V_NEG,  1'b0, 1'b0, '0},
    '{V_NEG,  1'b0, 1'b0, '0},
    '{32'sd1, 1'b0, 1'b0, '0},
    '{V_NEG,  1'b1, 1'b1, '{V_NEG,  1'b0, 7'd2, 1'b0, 1'b1}},
    '{V_MAX,  1'b1, 1'b1, '{V_MAX,  1'b1, 7'd1, 1'b0, 1'b1}}
  };

  logic [VALUE_W-1:0] seen_tbl [DEPTH];
  int unsigned        seen_cnt;
  dedup_result_t      pending_results [$];

  int unsigned n_sent, n_results, n_errors, n_in_stall;
  int unsigned n_kept, n_dropped, n_ovf, n_sets;
  bit          calm;

  function automatic dedup_result_t dedup_predict(input logic signed [VALUE_W-1:0] v,
                                                  input logic l);
    dedup_result_t r;
    bit            found;
    found = 1'b0;
    for (int k = 0; k < int'(seen_cnt); k++) begin
      if (seen_tbl[k] == v) found = 1'b1;
    end
    r = '0;
    r.value_out  = v;
    r.end_of_set = l;
    if (!found) begin
      r.kept = 1'b1;
      if (seen_cnt < DEPTH) begin
        seen_tbl[seen_cnt] = v;
        seen_cnt++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    r.distinct_count = CNT_OUT_W'(seen_cnt);
    if (r.overflow) n_ovf++;
    if (r.kept) n_kept++;
    else n_dropped++;
    if (l) begin
      seen_cnt = 0;
      n_sets++;
    end
    return r;
  endfunction

  // mostly zero, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] b;
    b = 32'sd1 << $urandom_range(0, VALUE_W - 1);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7);
      1: return -$urandom_range(1, 8);
      2: begin
        case ($urandom_range(0, 3))
          0: return V_MIN;
          1: return V_MAX;
          2: return 32'sd0;
          default: return V_NEG;
        endcase
      end
      3: return b;
      4: return ~b;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l,
                           input dedup_result_t exp);
    int g;
    pending_results.push_back(exp);
    in_if.valid     <= 1'b1;
    in_if.value     <= v;
    in_if.last_item <= l;
    do begin
      @(posedge clk_i);
      if (!in_if.ready) n_in_stall++;
    end while (!in_if.ready);
    n_sent++;
    calm = ((n_sent / 150) % 4) == 1;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic check_result();
    dedup_result_t exp;
    n_results++;
    if (pending_results.size() == 0) begin
      $error("unexpected transaction: value_out %0d", out_if.value_out);
      n_errors++;
    end else begin
      exp = pending_results.pop_front();
      if (out_if.value_out !== exp.value_out) begin
        $error("value_out: expected %0d, got %0d", exp.value_out, out_if.value_out);
        n_errors++;
      end
      if (out_if.kept !== exp.kept) begin
        $error("kept: expected %0d, got %0d", exp.kept, out_if.kept);
        n_errors++;
      end
      if (out_if.distinct_count !== exp.distinct_count) begin
        $error("distinct_count: expected %0d, got %0d", exp.distinct_count,
               out_if.distinct_count);
        n_errors++;
      end
      if (out_if.overflow !== exp.overflow) begin
        $error("overflow: expected %0d, got %0d", exp.overflow, out_if.overflow);
        n_errors++;
      end
      if (out_if.end_of_set !== exp.end_of_set) begin
        $error("end_of_set: expected %0d, got %0d", exp.end_of_set, out_if.end_of_set);
        n_errors++;
      end
    end
  endtask

  initial begin : tx_proc
    dedup_result_t             pred;
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] set_vals [$];
    int                        kind;
    int                        len;
    seen_cnt = 0;
    calm     = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.value     <= '0;
    in_if.last_item <= 1'b0;
    rst_ni          <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      pred = dedup_predict(dir_rows[i].value, dir_rows[i].last);
      send_item(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed ? dir_rows[i].exp : pred);
    end

    // short sets rich in duplicates, medium sets, and long sets that may overrun the table
    while (n_sent < N_DIR + N_RANDOM) begin
      kind = $urandom_range(0, 9);
      len  = (kind < 5) ? $urandom_range(1, 8) :
             (kind < 8) ? $urandom_range(9, 50) : $urandom_range(60, 110);
      set_vals.delete();
      for (int k = 0; k < len; k++) begin
        if (set_vals.size() > 0 && $urandom_range(0, 4) == 0)
          v = set_vals[$urandom_range(0, set_vals.size() - 1)];
        else if (kind >= 8)
          v = $urandom();
        else
          v = pick_value();
        set_vals.push_back(v);
        send_item(v, k == len - 1, dedup_predict(v, k == len - 1));
      end
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 20) @(posedge clk_i);

    $display("%0d items in %0d sets: %0d kept, %0d dropped, %0d with table overflow",
             n_sent, n_sets, n_kept, n_dropped, n_ovf);
    $display("%0d results checked, input back-pressured for %0d cycles",
             n_results, n_in_stall);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : rx_proc
    int unsigned stall_left;
    bit          held;
    stall_left = 0;
    held       = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) check_result();
      // one long hold-off so the chain fills and the input stalls
      if (!held && n_results == 300) begin
        stall_left = 400;
        held       = 1'b1;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== order_preserving_dedup.f =====
rtl/core/opd_pkg.sv
rtl/core/opd_in_if.sv
rtl/core/opd_out_if.sv
rtl/core/opd_cell.sv
rtl/core/order_preserving_dedup.sv
rtl/core/opd_checker.sv
tb/tb_order_preserving_dedup.sv
